[hdl/ctcsd_pkg.sv]
// ctcsd_pkg: shared types, constants and table functions of the ctc subblock deinterleaver
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies
package ctcsd_pkg;

  localparam int SLOT_BITS     = 48;
  localparam int SLOT_HALF     = SLOT_BITS / 2;
  localparam int SUBBLOCKS     = 6;
  localparam int DEF_MAX_SLOTS = 10;
  localparam int DEF_LLR_WIDTH = 8;

  localparam int NUM_SLOTS_W = 4;
  localparam int RPS_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [NUM_SLOTS_W-1:0] NUM_SLOTS_RESET = NUM_SLOTS_W'(1);
  localparam logic [NUM_SLOTS_W-1:0] FORBIDDEN_SLOTS = NUM_SLOTS_W'(7);
  localparam logic [RPS_W-1:0]       RPS_RESET       = RPS_W'(96);
  localparam logic [RPS_W-1:0]       RPS_LIMIT       = RPS_W'(3 * SLOT_BITS);

  // permutation generator widths
  localparam int KQ_W  = 7;
  localparam int KJ_W  = 2;
  localparam int M_W   = 3;
  localparam int J_W   = 3;
  localparam int T_W   = 9;
  localparam int BLK_W = 3;

  localparam logic [BLK_W-1:0] BLK_WRAP = BLK_W'(SUBBLOCKS);
  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(SUBBLOCKS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SLOTS = 2'd0,
    CFG_RECEIVED  = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_PULL = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_BUILD,
    S_SPLIT,
    S_IDLE,
    S_PERM,
    S_DELIVER
  } state_t;

  typedef struct packed {
    logic cfg_write;
    logic init;
    logic build;
    logic split;
    logic load;
    logic pull;
    logic fetch;
    logic deliver;
  } ctcsd_cmd_t;

  typedef struct packed {
    logic rebuild_req;
    logic build_done;
    logic split_done;
  } ctcsd_status_t;

  function automatic logic [M_W-1:0] perm_m(input logic [NUM_SLOTS_W-1:0] n);
    logic [M_W-1:0] m;
    unique case (n)
      4'd1:    m = 3'd3;
      4'd2:    m = 3'd4;
      4'd3:    m = 3'd5;
      4'd4:    m = 3'd5;
      4'd5:    m = 3'd6;
      4'd6:    m = 3'd6;
      4'd8:    m = 3'd6;
      4'd9:    m = 3'd6;
      4'd10:   m = 3'd7;
      default: m = 3'd3;
    endcase
    return m;
  endfunction

  function automatic logic [J_W-1:0] perm_j(input logic [NUM_SLOTS_W-1:0] n);
    logic [J_W-1:0] j;
    unique case (n)
      4'd5:    j = 3'd2;
      4'd9:    j = 3'd4;
      4'd10:   j = 3'd2;
      default: j = 3'd3;
    endcase
    return j;
  endfunction

  // reverse the low m bits of v (v below 2^m)
  function automatic logic [KQ_W-1:0] bitrev(input logic [KQ_W-1:0] v,
                                             input logic [M_W-1:0] m);
    logic [KQ_W-1:0] r;
    for (int b = 0; b < KQ_W; b++) begin
      r[KQ_W-1-b] = v[b];
    end
    return r >> (M_W'(KQ_W) - m);
  endfunction

  function automatic logic slots_ok(input logic [NUM_SLOTS_W-1:0] v, input int max_slots);
    return (v != '0) && (int'(v) <= max_slots) && (v != FORBIDDEN_SLOTS);
  endfunction

endpackage

[hdl/ctcsd_if.sv]
// ctcsd channel interfaces: input items, result items and configuration writes
// valid/ready handshake, a transaction completes when both are high at a clock edge
// depends on ctcsd_pkg
interface ctcsd_in_if #(
  parameter int LLR_W = ctcsd_pkg::DEF_LLR_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [LLR_W-1:0] llr;

  modport source (output valid, output mode, output llr, input ready);
  modport sink   (input valid, input mode, input llr, output ready);
endinterface

interface ctcsd_out_if #(
  parameter int LLR_W = ctcsd_pkg::DEF_LLR_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic signed [LLR_W-1:0] soft_out;
  logic                    last;

  modport source (output valid, output soft_out, output last, input ready);
  modport sink   (input valid, input soft_out, input last, output ready);
endinterface

interface ctcsd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ctcsd_pkg::CFG_IDX_W-1:0]     index;
  logic [ctcsd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/ctcsd_ctrl.sv]
// ctcsd_ctrl: controller state machine of the ctc subblock deinterleaver
// sequences table rebuild, loads and pulls, owns the handshakes and result valid
// depends on ctcsd_pkg
module ctcsd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     items_valid,
  input  logic                     items_mode,
  output logic                     items_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     results_ready,
  output logic                     results_valid,
  input  ctcsd_pkg::ctcsd_status_t status,
  output ctcsd_pkg::ctcsd_cmd_t    cmd
);
  import ctcsd_pkg::*;

  state_t state;
  state_t state_next;
  logic   results_valid_next;
  logic   item_acc;
  logic   out_free;

  assign out_free = !results_valid || results_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      results_valid <= 1'b0;
    end else begin
      state         <= state_next;
      results_valid <= results_valid_next;
    end
  end

  // outputs
  always_comb begin
    cfg_ready   = (state == S_IDLE);
    items_ready = (state == S_IDLE) && !cfg_valid;
    item_acc    = items_valid && items_ready;
    cmd           = '0;
    cmd.cfg_write = cfg_valid && cfg_ready;
    cmd.init      = (state == S_INIT);
    cmd.build     = (state == S_BUILD);
    cmd.split     = (state == S_SPLIT);
    cmd.load      = item_acc && (items_mode == MODE_LOAD);
    cmd.pull      = item_acc && (items_mode == MODE_PULL);
    cmd.fetch     = (state == S_PERM);
    cmd.deliver   = (state == S_DELIVER) && out_free;
    results_valid_next = cmd.deliver || (results_valid && !results_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:    state_next = S_BUILD;
      S_BUILD:   if (status.build_done) state_next = S_SPLIT;
      S_SPLIT:   if (status.split_done) state_next = S_IDLE;
      S_IDLE: begin
        priority if (status.rebuild_req) state_next = S_INIT;
        else if (item_acc && (items_mode == MODE_PULL)) state_next = S_PERM;
        else state_next = S_IDLE;
      end
      S_PERM:    state_next = S_DELIVER;
      S_DELIVER: if (out_free) state_next = S_IDLE;
      default:   state_next = S_INIT;
    endcase
  end

endmodule

[hdl/ctcsd_datapath.sv]
// ctcsd_datapath: configuration registers, counters, permutation table and soft store
// executes the controller's commands, reports build and split progress
// depends on ctcsd_pkg
module ctcsd_datapath #(
  parameter int MAX_SLOTS = ctcsd_pkg::DEF_MAX_SLOTS,
  parameter int LLR_WIDTH = ctcsd_pkg::DEF_LLR_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ctcsd_pkg::ctcsd_cmd_t               cmd,
  output ctcsd_pkg::ctcsd_status_t            status,
  input  logic signed [LLR_WIDTH-1:0]         llr,
  input  logic [ctcsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctcsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic signed [LLR_WIDTH-1:0]         soft_out,
  output logic                                last
);
  import ctcsd_pkg::*;

  localparam int SUB_MAX     = MAX_SLOTS * SLOT_HALF;
  localparam int STORE_DEPTH = SUB_MAX * SUBBLOCKS;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PERM_AW     = $clog2(SUB_MAX);
  localparam int SW          = $clog2(SUB_MAX + 1);

  localparam logic signed [LLR_WIDTH-1:0] LLR_MIN = {1'b1, {(LLR_WIDTH-1){1'b0}}};
  localparam logic signed [LLR_WIDTH-1:0] LLR_MAX = {1'b0, {(LLR_WIDTH-1){1'b1}}};

  logic [NUM_SLOTS_W-1:0] num_slots;
  logic [RPS_W-1:0]       received_per_slot;

  logic [CNT_W-1:0]   load_count;
  logic [CNT_W-1:0]   pull_count;
  logic [BLK_W-1:0]   blk;
  logic [PERM_AW-1:0] pos;
  logic               wrap;

  logic [KJ_W-1:0]  kj;
  logic [KQ_W-1:0]  kq;
  logic [SW-1:0]    perm_i;
  logic [CNT_W-1:0] rem;

  logic [PERM_AW-1:0]          q;
  logic signed [LLR_WIDTH-1:0] store_rd;
  logic                        hit;
  logic                        last_p;

  logic [PERM_AW-1:0]          perm_mem  [SUB_MAX];
  logic signed [LLR_WIDTH-1:0] store_mem [STORE_DEPTH];

  logic [SW-1:0]            sub_len;
  logic [RPS_W-1:0]         rps_lim;
  logic [11:0]              bound_full;
  logic [CNT_W-1:0]         bound;
  logic [CNT_W-1:0]         valid_cnt;
  logic [M_W-1:0]           m;
  logic [J_W-1:0]           j;
  logic [T_W-1:0]           t;
  logic                     t_hit;
  logic                     last_k;
  logic                     slots_write;
  logic [CNT_W-1:0]         base;
  logic [PERM_AW:0]         offset;
  logic [CNT_W-1:0]         idx;
  logic                     is_last;
  logic                     pos_end;
  logic [CNT_W-1:0]         o_cnt;
  logic signed [LLR_WIDTH-1:0] neg;

  // block geometry
  assign sub_len    = SW'(({5'd0, num_slots} << 4) + ({5'd0, num_slots} << 3));
  assign rps_lim    = (received_per_slot > RPS_LIMIT) ? RPS_LIMIT : received_per_slot;
  assign bound_full = 12'(rps_lim) * 12'(num_slots);
  assign bound      = CNT_W'(bound_full);
  assign valid_cnt  = (load_count < bound) ? load_count : bound;

  // permutation generator: t = 2^m * (k mod J) + bitrev_m(k div J)
  assign m      = perm_m(num_slots);
  assign j      = perm_j(num_slots);
  assign t      = (T_W'(kj) << m) + T_W'(bitrev(kq, m));
  assign t_hit  = t < T_W'(sub_len);
  assign last_k = (kj == KJ_W'(j - J_W'(1))) && (kq == KQ_W'((8'd1 << m) - 8'd1));

  assign slots_write = cmd.cfg_write && (cfg_index == CFG_NUM_SLOTS)
                       && slots_ok(cfg_data[NUM_SLOTS_W-1:0], MAX_SLOTS);

  assign status.rebuild_req = slots_write;
  assign status.build_done  = (t_hit && ((perm_i + SW'(1)) == sub_len)) || last_k;
  assign status.split_done  = (blk == BLK_WRAP) || (rem < CNT_W'(sub_len));

  // stream address of the pulled value, y and w pairs interleaved
  always_comb begin
    unique case (blk)
      3'd0:       base = '0;
      3'd1:       base = CNT_W'(sub_len);
      3'd2, 3'd3: base = CNT_W'(sub_len) << 1;
      default:    base = CNT_W'(sub_len) << 2;
    endcase
    offset = (blk < 3'd2) ? {1'b0, q} : {q, blk[0]};
    idx    = base + CNT_W'(offset);
  end

  assign pos_end = (SW'(pos) == sub_len - SW'(1));
  assign is_last = (blk == BLK_LAST) && pos_end;
  assign o_cnt   = wrap ? '0 : pull_count;
  assign neg     = (llr == LLR_MIN) ? LLR_MAX : -llr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_slots         <= NUM_SLOTS_RESET;
      received_per_slot <= RPS_RESET;
    end else if (cmd.cfg_write) begin
      if (slots_write) num_slots <= cfg_data[NUM_SLOTS_W-1:0];
      if (cfg_index == CFG_RECEIVED) received_per_slot <= cfg_data[RPS_W-1:0];
    end
  end

  // load and pull position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pull_count <= '0;
      blk        <= '0;
      pos        <= '0;
      wrap       <= 1'b0;
    end else begin
      if (cmd.init) begin
        blk <= '0;
      end else if (cmd.split) begin
        if (!status.split_done) begin
          blk <= blk + BLK_W'(1);
        end else if (blk == BLK_WRAP) begin
          blk  <= '0;
          pos  <= '0;
          wrap <= 1'b1;
        end else begin
          pos  <= rem[PERM_AW-1:0];
          wrap <= 1'b0;
        end
      end else if (cmd.load) begin
        if (load_count < bound) load_count <= load_count + CNT_W'(1);
      end else if (cmd.fetch) begin
        wrap <= 1'b0;
        if (is_last) begin
          pull_count <= '0;
          load_count <= '0;
          blk        <= '0;
          pos        <= '0;
        end else begin
          pull_count <= o_cnt + CNT_W'(1);
          if (pos_end) begin
            pos <= '0;
            blk <= blk + BLK_W'(1);
          end else begin
            pos <= pos + PERM_AW'(1);
          end
        end
      end
    end
  end

  // table generator counters and pull count split
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      kj     <= '0;
      kq     <= '0;
      perm_i <= '0;
      rem    <= pull_count;
    end else if (cmd.build) begin
      if (t_hit) perm_i <= perm_i + SW'(1);
      if (kj == KJ_W'(j - J_W'(1))) begin
        kj <= '0;
        kq <= kq + KQ_W'(1);
      end else begin
        kj <= kj + KJ_W'(1);
      end
    end else if (cmd.split && !status.split_done) begin
      rem <= rem - CNT_W'(sub_len);
    end
  end

  // inverse permutation table
  always_ff @(posedge clk) begin
    if (cmd.build && t_hit) perm_mem[t[PERM_AW-1:0]] <= perm_i[PERM_AW-1:0];
    if (cmd.pull) q <= perm_mem[pos];
  end

  // soft value store
  always_ff @(posedge clk) begin
    if (cmd.load && (load_count < bound)) store_mem[load_count[ADDR_W-1:0]] <= neg;
    if (cmd.fetch) store_rd <= store_mem[idx[ADDR_W-1:0]];
  end

  // fetch flags and result payload
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      hit    <= idx < valid_cnt;
      last_p <= is_last;
    end
    if (cmd.deliver) begin
      soft_out <= hit ? store_rd : '0;
      last     <= last_p;
    end
  end

endmodule

[hdl/ctc_subblock_deinterleaver.sv]
// ctc_subblock_deinterleaver: top level of the ctc subblock deinterleaver
// joins the controller and the datapath to the item, result and configuration channels
// depends on ctcsd_pkg, ctcsd_if, ctcsd_ctrl, ctcsd_datapath

// Receive-side subblock deinterleaver for the 802.16 convolutional turbo code. A load
// transaction (mode 0) stores one soft value, negated and saturated, at the next stream
// position; loads beyond received_per_slot (capped at 144) times num_slots are dropped.
// A pull transaction (mode 1) returns the next value of subblocks A, B, Y1, Y2, W1, W2
// in deinterleaved order, each subblock num_slots*24 values long; positions never loaded
// read as zero, and the pull that returns last resets both counters. In a pull the
// inverse permutation table read and the soft store read are chained, and the value then
// goes to the result register; the next transaction is taken while the result still
// waits. After reset and after every accepted num_slots write the inverse permutation
// table is regenerated, one candidate index per cycle, and the pull counter is re-split
// into subblock and position; no transaction is accepted until both are done. Writes of
// num_slots that are 0, 7 or above MAX_SLOTS are ignored, as are writes to unknown
// register indexes.
module ctc_subblock_deinterleaver #(
  parameter int MAX_SLOTS = ctcsd_pkg::DEF_MAX_SLOTS,
  parameter int LLR_WIDTH = ctcsd_pkg::DEF_LLR_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  ctcsd_in_if.sink      items,
  ctcsd_out_if.source   results,
  ctcsd_cfg_if.sink     cfg
);
  import ctcsd_pkg::*;

  ctcsd_cmd_t    cmd;
  ctcsd_status_t status;

  // controller: sequencing and all handshakes
  ctcsd_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .items_valid   (items.valid),
    .items_mode    (items.mode),
    .items_ready   (items.ready),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .results_ready (results.ready),
    .results_valid (results.valid),
    .status        (status),
    .cmd           (cmd)
  );

  // datapath: registers, counters, table and store
  ctcsd_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .LLR_WIDTH (LLR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .llr       (items.llr),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .soft_out  (results.soft_out),
    .last      (results.last)
  );

  // a configuration write and an item transaction never complete together
  a_cfg_item_excl: assert property (@(posedge clk) disable iff (rst)
    !(cfg.valid && cfg.ready && items.valid && items.ready))
    else $error("configuration write and item transaction in the same cycle");

  // every accepted pull reads the store in the following cycle
  a_pull_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.pull |=> cmd.fetch)
    else $error("pull not followed by store read");

  // a result only appears after a deliver command loaded the result register
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.deliver))
    else $error("result valid without deliver");

  // no transaction is accepted in the cycle after reset while the table is rebuilt
  a_init_block: assert property (@(posedge clk)
    $past(rst) |-> !items.ready && !cfg.ready)
    else $error("transaction accepted during table rebuild after reset");

endmodule
